// ===== rtl/bksp_pkg.sv =====
`default_nettype none

package bksp_pkg;

    localparam int KNOT_W  = 32;
    localparam int INDEX_W = 6;
    // search indices reach last control index plus one, so one bit more
    localparam int SPAN_W  = 7;
    localparam int CFG_W   = 6;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_FIND  = 1'b1
    } op_t;

    typedef enum logic
    {
        REG_LAST_CTRL = 1'b0,
        REG_DEGREE    = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_END,
        ST_LOW,
        ST_MID,
        ST_MID1
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/bksp_ram.sv =====
`default_nettype none

module bksp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bspline_knot_span_search.sv =====
`default_nettype none

// B-spline knot span search. A write transaction (operation = 0) stores one
// knot, gives no result and leaves busy low. A find transaction
// (operation = 1) holds busy high and strobes done with span_index and
// out_of_domain when the end-knot checks settle the answer or the binary
// search ends (about log2 of last_ctrl_index + 2 - degree steps for an
// ordered knot vector, at most MAX_KNOTS for a disordered one). The knot
// memory has a single read port: the two end knots are read first, then
// each step reads the midpoint knot and its successor. The result is held
// for exactly one cycle and must be taken then; a new transaction may be
// started in that same cycle. Only write configuration while busy is low.
// Knots must be written before any find reads them.
module bspline_knot_span_search #(
    parameter int MAX_KNOTS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [bksp_pkg::CFG_W-1:0]          cfg_data,

    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                operation,
    input  wire logic [bksp_pkg::INDEX_W-1:0]        knot_index,
    input  wire logic signed [bksp_pkg::KNOT_W-1:0]  knot_value,
    input  wire logic signed [bksp_pkg::KNOT_W-1:0]  param_value,

    output logic                                     done,
    output logic [bksp_pkg::INDEX_W-1:0]             span_index,
    output logic                                     out_of_domain
);

    import bksp_pkg::*;

    localparam int AW   = $clog2(MAX_KNOTS);
    localparam int SW   = $clog2(MAX_KNOTS);
    localparam int NMAX = (MAX_KNOTS - 2 > 63) ? 63 : MAX_KNOTS - 2;

    state_t state_reg, state_next;

    logic [INDEX_W-1:0]       last_ctrl_reg;
    logic [3:0]               degree_reg;

    logic signed [KNOT_W-1:0] u_reg, u_next;
    logic signed [KNOT_W-1:0] end_reg, end_next;
    logic signed [KNOT_W-1:0] kmid_reg, kmid_next;
    logic [INDEX_W-1:0]       lo_reg, lo_next;
    logic [SPAN_W-1:0]        hi_reg, hi_next;
    logic [INDEX_W-1:0]       mid_reg, mid_next;
    logic [SW-1:0]            step_reg, step_next;
    logic                     done_reg, done_next;
    logic [INDEX_W-1:0]       span_reg, span_next;
    logic                     ood_reg, ood_next;

    logic [INDEX_W-1:0]       n_c;
    logic [INDEX_W-1:0]       p_c;
    logic [SPAN_W-1:0]        n1_c;

    logic                     accept;
    logic                     ram_we;
    logic                     ram_re;
    logic [SPAN_W-1:0]        rd_index;
    logic signed [KNOT_W-1:0] rdata;

    // decisions
    logic                     at_end, below, above, domain_exit;
    logic                     hit, go_left, collapse, last_step;
    logic [INDEX_W-1:0]       lo_upd;
    logic [SPAN_W-1:0]        hi_upd;
    logic [INDEX_W-1:0]       mid_upd;
    logic [INDEX_W-1:0]       mid_first;
    logic [SPAN_W-1:0]        sum_first, sum_upd;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // clamp n so that knot n+1 exists, then p to n
    assign n_c  = (last_ctrl_reg > INDEX_W'(NMAX)) ? INDEX_W'(NMAX) : last_ctrl_reg;
    assign p_c  = ({2'b00, degree_reg} > n_c) ? n_c : {2'b00, degree_reg};
    assign n1_c = {1'b0, n_c} + SPAN_W'(1);

    assign ram_we = accept && (operation == OP_WRITE) && (int'(knot_index) < MAX_KNOTS);

    bksp_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (MAX_KNOTS)
    ) u_knots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(knot_index)),
        .wdata (knot_value),
        .re    (ram_re),
        .raddr (AW'(rd_index)),
        .rdata (rdata)
    );

    always_comb
    begin
        at_end      = (u_reg == end_reg);
        below       = (u_reg < rdata);
        above       = (u_reg > end_reg);
        domain_exit = at_end || below || above;
        sum_first   = {1'b0, p_c} + n1_c;
        mid_first   = sum_first[SPAN_W-1:1];

        go_left     = (u_reg < kmid_reg);
        hit         = !(go_left || (u_reg >= rdata));
        lo_upd      = go_left ? lo_reg : mid_reg;
        hi_upd      = go_left ? {1'b0, mid_reg} : hi_reg;
        collapse    = (hi_upd <= {1'b0, lo_upd});
        sum_upd     = {1'b0, lo_upd} + hi_upd;
        mid_upd     = sum_upd[SPAN_W-1:1];
        last_step   = (step_reg == SW'(MAX_KNOTS - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_FIND))
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                state_next = ST_LOW;
            end
            ST_LOW:
            begin
                state_next = domain_exit ? ST_IDLE : ST_MID;
            end
            ST_MID:
            begin
                state_next = ST_MID1;
            end
            ST_MID1:
            begin
                state_next = (hit || collapse || last_step) ? ST_IDLE : ST_MID;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory reads
    always_comb
    begin
        u_next    = u_reg;
        end_next  = end_reg;
        kmid_next = kmid_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        step_next = step_reg;
        done_next = 1'b0;
        span_next = span_reg;
        ood_next  = ood_reg;
        ram_re    = 1'b0;
        rd_index  = n1_c;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_FIND))
                begin
                    u_next   = param_value;
                    ram_re   = 1'b1;
                    rd_index = n1_c;
                end
            end
            ST_END:
            begin
                end_next = rdata;
                ram_re   = 1'b1;
                rd_index = {1'b0, p_c};
            end
            ST_LOW:
            begin
                // rdata holds the knot at the degree
                if (at_end)
                begin
                    done_next = 1'b1;
                    span_next = n_c;
                    ood_next  = 1'b0;
                end
                else if (below)
                begin
                    done_next = 1'b1;
                    span_next = p_c;
                    ood_next  = 1'b1;
                end
                else if (above)
                begin
                    done_next = 1'b1;
                    span_next = n_c;
                    ood_next  = 1'b1;
                end
                else
                begin
                    lo_next   = p_c;
                    hi_next   = n1_c;
                    mid_next  = mid_first;
                    step_next = '0;
                    ram_re    = 1'b1;
                    rd_index  = {1'b0, mid_first};
                end
            end
            ST_MID:
            begin
                kmid_next = rdata;
                ram_re    = 1'b1;
                rd_index  = {1'b0, mid_reg} + SPAN_W'(1);
            end
            ST_MID1:
            begin
                if (hit || collapse)
                begin
                    done_next = 1'b1;
                    span_next = mid_reg;
                    ood_next  = 1'b0;
                end
                else if (last_step)
                begin
                    // step budget spent: the fresh midpoint stands
                    done_next = 1'b1;
                    span_next = mid_upd;
                    ood_next  = 1'b0;
                end
                else
                begin
                    lo_next   = lo_upd;
                    hi_next   = hi_upd;
                    mid_next  = mid_upd;
                    step_next = step_reg + SW'(1);
                    ram_re    = 1'b1;
                    rd_index  = {1'b0, mid_upd};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            last_ctrl_reg <= INDEX_W'(1);
            degree_reg    <= 4'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LAST_CTRL: last_ctrl_reg <= cfg_data[INDEX_W-1:0];
                    REG_DEGREE:    degree_reg    <= cfg_data[3:0];
                    default:       degree_reg    <= degree_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        end_reg  <= end_next;
        kmid_reg <= kmid_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        step_reg <= step_next;
        span_reg <= span_next;
        ood_reg  <= ood_next;
    end

    assign done          = done_reg;
    assign span_index    = span_reg;
    assign out_of_domain = ood_reg;

    // result only follows the end-knot check or a search step
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_LOW || $past(state_reg) == ST_MID1))
        else $error("done without a finishing search state");

    // the strobe cycle never overlaps a find in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // midpoint stays inside the search interval
    a_mid_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID) |-> (mid_reg >= lo_reg && {1'b0, mid_reg} < hi_reg))
        else $error("midpoint outside interval");

    // a write transaction never starts a search
    a_write_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_WRITE) |=> (state_reg == ST_IDLE && !done))
        else $error("write transaction started a search");

endmodule

`default_nettype wire

// ===== bench/tb_bspline_knot_span_search.sv =====
`default_nettype none

module tb_bspline_knot_span_search;

    timeunit 1ns;
    timeprecision 1ps;

    import bksp_pkg::*;

    localparam int MAX_KNOTS   = 64;
    localparam int N_DIRECTED  = 19;
    localparam int N_PHASES    = 10;
    localparam int FINDS_PER_PHASE = 130;
    localparam int SPAN_LATENCY = 3 + 2 * MAX_KNOTS + 8;

    typedef struct packed
    {
        logic [INDEX_W-1:0] span;
        logic               flag;
    } span_res_t;

    typedef struct packed
    {
        op_t                       op;
        logic [INDEX_W-1:0]        idx;
        logic signed [KNOT_W-1:0]  kval;
        logic signed [KNOT_W-1:0]  pval;
        logic                      typed;
        logic [INDEX_W-1:0]        span;
        logic                      flag;
    } dir_row_t;

    // Reset settings (last control index 1, degree 1): the domain is knots 1..2, so
    // every answer is span 1 and only the flag moves.
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_WRITE, 6'd1,  32'sh8000_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_WRITE, 6'd2,  32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b0, 6'd0, 1'b0},
        '{OP_FIND,  6'd63, 32'sh0000_0000, 32'sh8000_0000, 1'b1, 6'd1, 1'b0},
        '{OP_FIND,  6'd0,  32'shFFFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 6'd1, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_WRITE, 6'd1,  32'sh0000_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_WRITE, 6'd2,  32'sh0001_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'shFFFF_FFFF, 1'b1, 6'd1, 1'b1},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0001_0001, 1'b1, 6'd1, 1'b1},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh8000_0000, 1'b1, 6'd1, 1'b1},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh7FFF_FFFF, 1'b1, 6'd1, 1'b1},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0000_8000, 1'b0, 6'd0, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0000_0000, 1'b1, 6'd1, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0001_0000, 1'b1, 6'd1, 1'b0},
        // repeated knot, then a knot vector running backwards
        '{OP_WRITE, 6'd2,  32'sh0000_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'sh0000_0000, 1'b1, 6'd1, 1'b0},
        '{OP_WRITE, 6'd2,  32'shFFFF_0000, 32'sh0000_0000, 1'b0, 6'd0, 1'b0},
        '{OP_FIND,  6'd0,  32'sh0000_0000, 32'shFFFF_8000, 1'b1, 6'd1, 1'b1},
        '{OP_WRITE, 6'd63, 32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0, 6'd0, 1'b0}
    };

    // -1 picks a random setting
    localparam int PHASE_LAST_CTRL [N_PHASES] = '{62, 1, 63, 0, 0, 5, 40, 62, -1, -1};
    localparam int PHASE_DEGREE    [N_PHASES] = '{15, 1, 15, 0, 7, 9, 3, 0, -1, -1};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      start;
    logic                      busy;
    logic                      operation;
    logic [INDEX_W-1:0]        knot_index;
    logic signed [KNOT_W-1:0]  knot_value;
    logic signed [KNOT_W-1:0]  param_value;
    logic                      done;
    logic [INDEX_W-1:0]        span_index;
    logic                      out_of_domain;

    bspline_knot_span_search #(
        .MAX_KNOTS (MAX_KNOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .knot_index    (knot_index),
        .knot_value    (knot_value),
        .param_value   (param_value),
        .done          (done),
        .span_index    (span_index),
        .out_of_domain (out_of_domain)
    );

    // shadow of the block's state
    logic signed [KNOT_W-1:0]  knot_mem [MAX_KNOTS];
    logic [5:0]                shadow_last_ctrl;
    logic [3:0]                shadow_degree;

    span_res_t pending_spans [$];

    int err_count;
    int n_finds;
    int n_writes;
    int n_outside;
    int n_settings;
    int burst_left;
    bit gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d spans still awaited", $realtime, pending_spans.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic span_res_t predict_span(logic signed [KNOT_W-1:0] u);
        int n;
        int p;
        int lo;
        int hi;
        int mid;
        span_res_t r;
        n = shadow_last_ctrl;
        if (n > MAX_KNOTS - 2)
            n = MAX_KNOTS - 2;
        p = shadow_degree;
        if (p > n)
            p = n;
        r.flag = 1'b0;
        if (u == knot_mem[n + 1])
        begin
            r.span = INDEX_W'(n);
            return r;
        end
        if (u < knot_mem[p])
        begin
            r.span = INDEX_W'(p);
            r.flag = 1'b1;
            return r;
        end
        if (u > knot_mem[n + 1])
        begin
            r.span = INDEX_W'(n);
            r.flag = 1'b1;
            return r;
        end
        lo  = p;
        hi  = n + 1;
        mid = (lo + hi) / 2;
        // bounded so that a disordered knot vector still ends
        for (int steps = 0; steps < MAX_KNOTS; steps++)
        begin
            if (!(u < knot_mem[mid] || u >= knot_mem[mid + 1]))
                break;
            if (u < knot_mem[mid])
                hi = mid;
            else
                lo = mid;
            if (hi <= lo)
                break;
            mid = (lo + hi) / 2;
        end
        r.span = INDEX_W'(mid);
        return r;
    endfunction

    // Called and returns at a falling edge. start is left high so that a following
    // transaction goes out back to back; a gap lowers it.
    task automatic issue(op_t op, logic [INDEX_W-1:0] idx, logic signed [KNOT_W-1:0] kval,
                         logic signed [KNOT_W-1:0] pval, logic typed, span_res_t typed_res);
        operation   <= op;
        knot_index  <= idx;
        knot_value  <= kval;
        param_value <= pval;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_WRITE)
        begin
            knot_mem[idx] = kval;
            n_writes++;
        end
        else
        begin
            pending_spans.push_back(typed ? typed_res : predict_span(pval));
            n_finds++;
        end
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_spans.size() != 0 || busy);
        repeat (3)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        span_res_t want;
        if (rst_n && done)
        begin
            if (pending_spans.size() == 0)
            begin
                $display("%0t: span result with none awaited: span %0d flag %0b",
                         $realtime, span_index, out_of_domain);
                err_count++;
            end
            else
            begin
                want = pending_spans.pop_front();
                if (span_index !== want.span)
                begin
                    $display("%0t: span_index expected %0d, got %0d",
                             $realtime, want.span, span_index);
                    err_count++;
                end
                if (out_of_domain !== want.flag)
                begin
                    $display("%0t: out_of_domain expected %0b, got %0b",
                             $realtime, want.flag, out_of_domain);
                    err_count++;
                end
            end
            if (out_of_domain === 1'b1)
                n_outside++;
        end
    end

    initial
    begin : stimulus
        int n_sel;
        int p_sel;
        int ns;
        int ps;
        int j;
        int kind;
        int style;
        longint v;
        longint step_max;
        longint lo_k;
        longint hi_k;
        longint u;
        logic [CFG_W-1:0] deg_data;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_LAST_CTRL;
        cfg_data    = '0;
        start       = 1'b0;
        operation   = OP_WRITE;
        knot_index  = '0;
        knot_value  = '0;
        param_value = '0;
        err_count   = 0;
        n_finds     = 0;
        n_writes    = 0;
        n_outside   = 0;
        n_settings  = 1;
        burst_left  = 0;
        gaps_on     = 1'b0;
        shadow_last_ctrl = 6'd1;
        shadow_degree    = 4'd1;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            issue(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].kval,
                  DIRECTED_ROWS[i].pval, DIRECTED_ROWS[i].typed,
                  '{span: DIRECTED_ROWS[i].span, flag: DIRECTED_ROWS[i].flag});
        settle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            n_sel = (PHASE_LAST_CTRL[ph] < 0) ? $urandom_range(0, 63) : PHASE_LAST_CTRL[ph];
            p_sel = (PHASE_DEGREE[ph] < 0) ? $urandom_range(0, 15) : PHASE_DEGREE[ph];
            // upper data bits above the degree field are junk the block must drop
            deg_data = {2'($urandom_range(0, 3)), 4'(p_sel)};
            cfg_we    <= 1'b1;
            cfg_index <= REG_LAST_CTRL;
            cfg_data  <= CFG_W'(n_sel);
            @(negedge clk);
            cfg_index <= REG_DEGREE;
            cfg_data  <= deg_data;
            @(negedge clk);
            cfg_we    <= 1'b0;
            shadow_last_ctrl = 6'(n_sel);
            shadow_degree    = deg_data[3:0];
            n_settings++;
            ns = (n_sel > MAX_KNOTS - 2) ? MAX_KNOTS - 2 : n_sel;
            ps = (p_sel > ns) ? ns : p_sel;

            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);

            // non-decreasing knot vector, with repeated knots and saturation at the top
            style = $urandom_range(0, 2);
            case (style)
                0:
                begin
                    v = longint'(int'($urandom));
                    step_max = 64'd1 << 26;
                end
                1:
                begin
                    v = -longint'($urandom_range(0, 1 << 20));
                    step_max = 64'd1 << 18;
                end
                default:
                begin
                    v = -64'sd2147483648;
                    step_max = 64'd1 << 27;
                end
            endcase
            for (int k = 0; k < MAX_KNOTS; k++)
            begin
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                issue(OP_WRITE, INDEX_W'(k), KNOT_W'(v), KNOT_W'($urandom), 1'b0, '0);
                if ($urandom_range(0, 3) != 0)
                    v += longint'($urandom) % (step_max + 1);
            end

            for (int f = 0; f < FINDS_PER_PHASE; f++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    // stray write that may break the ordering of the knots
                    issue(OP_WRITE, INDEX_W'($urandom), KNOT_W'($urandom), KNOT_W'($urandom),
                          1'b0, '0);
                    continue;
                end
                lo_k = longint'(knot_mem[ps]);
                hi_k = longint'(knot_mem[ns + 1]);
                j    = $urandom_range(ps, ns + 1);
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1:
                        u = longint'(knot_mem[j]);
                    2:
                        u = longint'(knot_mem[j]) + ($urandom_range(0, 1) ? 1 : -1);
                    3, 4, 5, 6:
                        u = (hi_k > lo_k) ? lo_k + longint'($urandom) % (hi_k - lo_k + 1) : lo_k;
                    7:
                        u = (lo_k > -64'sd2147483648)
                            ? lo_k - 1 - longint'($urandom) % (lo_k + 64'sd2147483648)
                            : longint'(int'($urandom));
                    8:
                        u = (hi_k < 64'sd2147483647)
                            ? hi_k + 1 + longint'($urandom) % (64'sd2147483647 - hi_k)
                            : longint'(int'($urandom));
                    default:
                        u = longint'(int'($urandom));
                endcase
                if (u > 64'sd2147483647)
                    u = 64'sd2147483647;
                if (u < -64'sd2147483648)
                    u = -64'sd2147483648;
                issue(OP_FIND, INDEX_W'($urandom), KNOT_W'($urandom), KNOT_W'(u), 1'b0, '0);
            end
            settle();
        end

        repeat (SPAN_LATENCY)
            @(posedge clk);

        $display("Covered %0d span searches (%0d outside the domain) and %0d knot writes",
                 n_finds, n_outside, n_writes);
        $display("across %0d register settings; %0d mismatches", n_settings, err_count);
        if (err_count == 0 && pending_spans.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bksp_pkg.sv
rtl/bksp_ram.sv
rtl/bspline_knot_span_search.sv
bench/tb_bspline_knot_span_search.sv
